>>> rtl/manhattan_nearest_site_area_macros.svh
// Assertion macros shared by the checker of the nearest-site area block.
`ifndef MANHATTAN_NEAREST_SITE_AREA_MACROS_SVH
`define MANHATTAN_NEAREST_SITE_AREA_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MNSA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MNSA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/mnsa_pkg.sv
// Package of the nearest-site area block: sizes, codes and shared types.
`timescale 1ns / 1ps
`default_nettype none

package mnsa_pkg;

  localparam int MAX_SITES  = 64;
  localparam int COORD_BITS = 11;

  localparam int ADDR_W  = $clog2(MAX_SITES);
  localparam int CNT_W   = $clog2(MAX_SITES + 1);
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int DSUM_W  = COORD_BITS + 2;

  // Field widths of the stream items and of the configuration register.
  localparam int OP_W      = 3;
  localparam int IDX_W     = 6;
  localparam int XY_W      = 11;
  localparam int DIST_W    = 12;
  localparam int AREA_W    = 20;
  localparam int CFG_W     = 7;
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 40;

  localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_LOAD     = 3'd0,
    OP_CLASSIFY = 3'd1,
    OP_CLEAR    = 3'd2,
    OP_READ     = 3'd3,
    OP_FIND     = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_WB,
    ST_DONE
  } state_e;

  // One word of the site memory.
  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [AREA_W-1:0]     area;
    logic                  grew;
  } site_t;

  // Running best candidate of a scan.
  typedef struct packed {
    logic [ADDR_W-1:0] idx;
    logic [DSUM_W-1:0] dsum;
    site_t             site;
    logic              shared;
  } best_t;

endpackage

`default_nettype wire

>>> rtl/manhattan_nearest_site_area.sv
// Top level of the nearest-site area block: site memory, sequencer and stream ports.
`timescale 1ns / 1ps
`default_nettype none

// Holds up to 64 sites (position, area counter, grew mark) in one single-port
// memory with a registered read and works on one transaction at a time. A
// transaction waits in its done state while the output side holds an earlier
// result back. The scan reads one site per cycle through the memory port. A
// classify credits the winner by writing its word back after the scan, so no
// read can meet the write. Area counters and grew marks are qualified by
// per-site valid flags, so no clearing pass follows reset. The next transaction
// is accepted while a result still waits on the output side.
module manhattan_nearest_site_area (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mnsa_pkg::CFG_W-1:0]        cfg_data_i,      // site_count
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // site_index [5:0], coord_x [16:6], coord_y [27:17], zero [31:28]
  input  logic [mnsa_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  input  logic [mnsa_pkg::OP_W-1:0]         s_axis_tuser,    // op [2:0]
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // nearest_index [5:0], tie [6], min_distance [18:7], area_count [38:19],
  // grew_mark [39]
  output logic [mnsa_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

  mnsa_pkg::state_e state_q, state_d;

  logic [mnsa_pkg::CFG_W-1:0]      site_count_q;
  logic [mnsa_pkg::CNT_W-1:0]      n_active;

  mnsa_pkg::op_e                   op_q;
  logic [mnsa_pkg::IDX_W-1:0]      idx_q;
  logic [mnsa_pkg::COORD_BITS-1:0] qx_q, qy_q;
  logic                            in_range_q;

  logic [mnsa_pkg::CNT_W-1:0]      issue_q, end_q;
  logic                            rd_vld_q;
  logic [mnsa_pkg::ADDR_W-1:0]     rd_idx_q;
  logic                            first_q;
  mnsa_pkg::best_t                 best_q, best_next;

  mnsa_pkg::site_t                 mem_q [mnsa_pkg::MAX_SITES];
  mnsa_pkg::site_t                 rd_data_q;
  mnsa_pkg::site_t                 rd_site;
  mnsa_pkg::site_t                 wr_data;
  logic [mnsa_pkg::ADDR_W-1:0]     mem_addr;
  logic                            mem_we, mem_re;

  logic [mnsa_pkg::MAX_SITES-1:0]  area_vld_q, grew_vld_q;

  logic                            m_valid_q;
  logic [mnsa_pkg::M_TDATA_W-1:0]  m_data_q;

  logic                            s_acc, issuing, out_free, idx_ok;
  mnsa_pkg::op_e                   in_op;
  logic [mnsa_pkg::AREA_W-1:0]     area_inc;
  logic [mnsa_pkg::DIST_W-1:0]     dist_sat;
  logic [mnsa_pkg::IDX_W-1:0]      r_index;
  logic                            r_tie, r_grew;
  logic [mnsa_pkg::DIST_W-1:0]     r_dist;
  logic [mnsa_pkg::AREA_W-1:0]     r_area;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == mnsa_pkg::ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign in_op         = mnsa_pkg::op_e'(s_axis_tuser);
  assign idx_ok        = 32'(s_axis_tdata[5:0]) < mnsa_pkg::MAX_SITES;
  assign issuing       = (state_q == mnsa_pkg::ST_SCAN) && (issue_q < end_q);
  assign out_free      = !m_valid_q || m_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // A count of zero acts as one; counts above the table size are clipped.
  always_comb begin
    if (site_count_q == '0) begin
      n_active = mnsa_pkg::CNT_W'(1);
    end else if (32'(site_count_q) > mnsa_pkg::MAX_SITES) begin
      n_active = mnsa_pkg::CNT_W'(mnsa_pkg::MAX_SITES);
    end else begin
      n_active = mnsa_pkg::CNT_W'(site_count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      site_count_q <= mnsa_pkg::CFG_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      site_count_q <= cfg_data_i;
    end
  end

  // Site read back from memory, with its counter and mark qualified.
  always_comb begin
    rd_site      = rd_data_q;
    rd_site.area = area_vld_q[rd_idx_q] ? rd_data_q.area : '0;
    rd_site.grew = area_vld_q[rd_idx_q] && grew_vld_q[rd_idx_q] && rd_data_q.grew;
  end

  mnsa_site_eval u_eval (
    .op_i    (op_q),
    .first_i (first_q),
    .idx_i   (rd_idx_q),
    .site_i  (rd_site),
    .qx_i    (qx_q),
    .qy_i    (qy_q),
    .best_i  (best_q),
    .best_o  (best_next)
  );

  assign area_inc = (best_q.site.area == mnsa_pkg::AREA_MAX) ? mnsa_pkg::AREA_MAX
                                                             : best_q.site.area + 1'b1;
  assign dist_sat = (32'(best_q.dsum) > 32'(mnsa_pkg::DIST_MAX)) ? mnsa_pkg::DIST_MAX
                                                                 : mnsa_pkg::DIST_W'(best_q.dsum);

  // Memory port control.
  always_comb begin
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = issue_q[mnsa_pkg::ADDR_W-1:0];
    wr_data  = best_q.site;
    case (state_q)
      mnsa_pkg::ST_LOAD: begin
        mem_we       = 1'b1;
        mem_addr     = mnsa_pkg::ADDR_W'(idx_q);
        wr_data.x    = qx_q;
        wr_data.y    = qy_q;
        wr_data.area = '0;
        wr_data.grew = 1'b0;
      end
      mnsa_pkg::ST_SCAN: begin
        mem_re = issuing;
      end
      mnsa_pkg::ST_WB: begin
        mem_we       = 1'b1;
        mem_addr     = best_q.idx;
        wr_data.area = area_inc;
        wr_data.grew = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= wr_data;
    end else if (mem_re) begin
      rd_data_q <= mem_q[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_vld_q <= '0;
      grew_vld_q <= '0;
    end else begin
      if (s_acc && (in_op == mnsa_pkg::OP_CLEAR)) begin
        grew_vld_q <= '0;
      end
      if (mem_we) begin
        area_vld_q[mem_addr] <= 1'b1;
        grew_vld_q[mem_addr] <= 1'b1;
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      mnsa_pkg::ST_IDLE: begin
        if (s_acc) begin
          case (in_op)
            mnsa_pkg::OP_LOAD:     state_d = idx_ok ? mnsa_pkg::ST_LOAD : mnsa_pkg::ST_DONE;
            mnsa_pkg::OP_CLASSIFY: state_d = mnsa_pkg::ST_SCAN;
            mnsa_pkg::OP_FIND:     state_d = mnsa_pkg::ST_SCAN;
            mnsa_pkg::OP_READ:     state_d = idx_ok ? mnsa_pkg::ST_SCAN : mnsa_pkg::ST_DONE;
            default:               state_d = mnsa_pkg::ST_DONE;
          endcase
        end
      end
      mnsa_pkg::ST_LOAD: begin
        state_d = mnsa_pkg::ST_DONE;
      end
      mnsa_pkg::ST_SCAN: begin
        // The last site is evaluated in the cycle after its read is issued.
        if (!issuing) begin
          if ((op_q == mnsa_pkg::OP_CLASSIFY) && !best_next.shared) begin
            state_d = mnsa_pkg::ST_WB;
          end else begin
            state_d = mnsa_pkg::ST_DONE;
          end
        end
      end
      mnsa_pkg::ST_WB: begin
        state_d = mnsa_pkg::ST_DONE;
      end
      mnsa_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = mnsa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mnsa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mnsa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Scan control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q  <= '0;
      end_q    <= '0;
      rd_vld_q <= 1'b0;
      rd_idx_q <= '0;
      first_q  <= 1'b0;
    end else begin
      rd_vld_q <= issuing;
      if (issuing) begin
        rd_idx_q <= issue_q[mnsa_pkg::ADDR_W-1:0];
        issue_q  <= issue_q + 1'b1;
      end
      if (rd_vld_q) begin
        first_q <= 1'b0;
      end
      if (s_acc) begin
        first_q <= 1'b1;
        if (in_op == mnsa_pkg::OP_READ) begin
          issue_q <= mnsa_pkg::CNT_W'(s_axis_tdata[5:0]);
          end_q   <= mnsa_pkg::CNT_W'(s_axis_tdata[5:0]) + 1'b1;
        end else begin
          issue_q <= '0;
          end_q   <= n_active;
        end
      end
    end
  end

  // Transaction payload and running best; no reset needed.
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      op_q       <= in_op;
      idx_q      <= s_axis_tdata[5:0];
      qx_q       <= mnsa_pkg::COORD_BITS'(s_axis_tdata[16:6]);
      qy_q       <= mnsa_pkg::COORD_BITS'(s_axis_tdata[27:17]);
      in_range_q <= idx_ok;
    end
    if (rd_vld_q) begin
      best_q <= best_next;
    end else if (state_q == mnsa_pkg::ST_WB) begin
      best_q.site.area <= area_inc;
      best_q.site.grew <= 1'b1;
    end
  end

  // Result fields.
  always_comb begin
    r_index = '0;
    r_tie   = 1'b0;
    r_dist  = '0;
    r_area  = '0;
    r_grew  = 1'b0;
    case (op_q)
      mnsa_pkg::OP_LOAD: begin
        r_index = idx_q;
      end
      mnsa_pkg::OP_CLASSIFY: begin
        r_index = mnsa_pkg::IDX_W'(best_q.idx);
        r_dist  = dist_sat;
        r_tie   = best_q.shared;
        r_area  = best_q.shared ? '0 : best_q.site.area;
        r_grew  = !best_q.shared && best_q.site.grew;
      end
      mnsa_pkg::OP_READ: begin
        r_index = idx_q;
        r_area  = in_range_q ? best_q.site.area : '0;
        r_grew  = in_range_q && best_q.site.grew;
      end
      mnsa_pkg::OP_FIND: begin
        r_index = mnsa_pkg::IDX_W'(best_q.idx);
        r_area  = best_q.site.area;
        r_grew  = best_q.site.grew;
      end
      default: begin
        r_index = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if ((state_q == mnsa_pkg::ST_DONE) && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == mnsa_pkg::ST_DONE) && out_free) begin
      m_data_q <= {r_grew, r_area, r_dist, r_tie, r_index};
    end
  end

endmodule

`default_nettype wire

>>> rtl/mnsa_site_eval.sv
// Per-site evaluation: Manhattan distance and update of the running best candidate.
`timescale 1ns / 1ps
`default_nettype none

module mnsa_site_eval (
  input  mnsa_pkg::op_e                      op_i,
  input  logic                               first_i,
  input  logic [mnsa_pkg::ADDR_W-1:0]        idx_i,
  input  mnsa_pkg::site_t                    site_i,
  input  logic [mnsa_pkg::COORD_BITS-1:0]    qx_i,
  input  logic [mnsa_pkg::COORD_BITS-1:0]    qy_i,
  input  mnsa_pkg::best_t                    best_i,
  output mnsa_pkg::best_t                    best_o
);

  logic [mnsa_pkg::DIFF_W-1:0] dx, dy, ax, ay;
  logic [mnsa_pkg::DSUM_W-1:0] man_d;
  logic                        better;
  mnsa_pkg::best_t             cand;

  always_comb begin
    dx = {site_i.x[mnsa_pkg::COORD_BITS-1], site_i.x} - {qx_i[mnsa_pkg::COORD_BITS-1], qx_i};
    dy = {site_i.y[mnsa_pkg::COORD_BITS-1], site_i.y} - {qy_i[mnsa_pkg::COORD_BITS-1], qy_i};
    ax = dx[mnsa_pkg::DIFF_W-1] ? (~dx + 1'b1) : dx;
    ay = dy[mnsa_pkg::DIFF_W-1] ? (~dy + 1'b1) : dy;
    man_d = {1'b0, ax} + {1'b0, ay};

    cand.idx    = idx_i;
    cand.dsum   = man_d;
    cand.site   = site_i;
    cand.shared = 1'b0;

    // Finite sites outrank grown ones; within a rank the larger area wins.
    if (site_i.grew == best_i.site.grew) begin
      better = site_i.area > best_i.site.area;
    end else begin
      better = !site_i.grew;
    end

    best_o = best_i;
    if (first_i) begin
      best_o = cand;
    end else begin
      case (op_i)
        mnsa_pkg::OP_CLASSIFY: begin
          if (man_d < best_i.dsum) begin
            best_o = cand;
          end else if (man_d == best_i.dsum) begin
            best_o.shared = 1'b1;
          end
        end
        mnsa_pkg::OP_FIND: begin
          if (better) begin
            best_o = cand;
          end
        end
        default: begin
          best_o = best_i;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/mnsa_checker.sv
// Port-level checker of the nearest-site area block and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
`include "manhattan_nearest_site_area_macros.svh"

module mnsa_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [mnsa_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

  // A stalled result holds its payload.
  `MNSA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // One transaction is worked on at a time.
  `MNSA_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, s_axis_tvalid && s_axis_tready,
    !s_axis_tready, "input accepted while busy")

  // A tie credits nothing.
  `MNSA_ASSERT_NOW(a_tie_no_credit, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[6],
    (m_axis_tdata[38:19] == '0) && !m_axis_tdata[39], "tie result carries a credit")

  // A grew mark is only ever set together with a credited area.
  `MNSA_ASSERT_NOW(a_grew_has_area, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[39],
    m_axis_tdata[38:19] != '0, "grown site with empty area")

endmodule

bind manhattan_nearest_site_area mnsa_checker u_mnsa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

>>> dv/manhattan_nearest_site_area_tb.sv
// Self-checking testbench of the nearest-site area block: stream stimulus, prediction and checks.
`timescale 1ns / 1ps

module manhattan_nearest_site_area_tb;

  localparam int          CYCLE_LIMIT  = 600000;
  localparam logic [2:0]  OP_LAST_CODE = 3'd7;
  localparam logic [10:0] COORD_MIN    = 11'h400;
  localparam logic [10:0] COORD_MAX    = 11'h3FF;

  // Result word, laid out so that a cast of m_axis_tdata lines up field by field.
  typedef struct packed {
    logic                        grew;
    logic [mnsa_pkg::AREA_W-1:0] area;
    logic [mnsa_pkg::DIST_W-1:0] min_d;
    logic                        tie;
    logic [mnsa_pkg::IDX_W-1:0]  idx;
  } site_result_t;

  class site_area_tracker;
    int unsigned  site_count;
    int           site_x[mnsa_pkg::MAX_SITES];
    int           site_y[mnsa_pkg::MAX_SITES];
    int unsigned  site_area[mnsa_pkg::MAX_SITES];
    bit           site_grew[mnsa_pkg::MAX_SITES];
    site_result_t expected_results[$];
    int unsigned  errors;

    function new();
      site_count = 1;
      errors = 0;
      foreach (site_area[i]) begin
        site_x[i] = 0;
        site_y[i] = 0;
        site_area[i] = 0;
        site_grew[i] = 0;
      end
    endfunction

    function int unsigned active_sites();
      if (site_count == 0) return 1;
      if (site_count > mnsa_pkg::MAX_SITES) return mnsa_pkg::MAX_SITES;
      return site_count;
    endfunction

    // Applies one accepted transaction to the tracked table and queues its result.
    function void note_query(logic [2:0] op, logic [mnsa_pkg::IDX_W-1:0] idx,
                             logic signed [mnsa_pkg::XY_W-1:0] cx,
                             logic signed [mnsa_pkg::XY_W-1:0] cy);
      site_result_t r;
      int unsigned  n, d, best_d;
      int           best, dx, dy;
      bit           shared, better;
      r = '0;
      n = active_sites();
      best = 0;
      best_d = 0;
      shared = 0;
      case (op)
        mnsa_pkg::OP_LOAD: begin
          r.idx = idx;
          site_x[idx] = int'(cx);
          site_y[idx] = int'(cy);
          site_area[idx] = 0;
          site_grew[idx] = 0;
        end
        mnsa_pkg::OP_CLASSIFY: begin
          for (int i = 0; i < n; i++) begin
            dx = site_x[i] - int'(cx);
            dy = site_y[i] - int'(cy);
            d = ((dx < 0) ? -dx : dx) + ((dy < 0) ? -dy : dy);
            if (i == 0 || d < best_d) begin
              best = i;
              best_d = d;
              shared = 0;
            end else if (d == best_d) begin
              shared = 1;
            end
          end
          r.idx = mnsa_pkg::IDX_W'(best);
          r.min_d = (best_d > mnsa_pkg::DIST_MAX) ? mnsa_pkg::DIST_MAX
                                                  : mnsa_pkg::DIST_W'(best_d);
          if (shared) begin
            r.tie = 1'b1;
          end else begin
            if (site_area[best] < mnsa_pkg::AREA_MAX) site_area[best]++;
            site_grew[best] = 1;
            r.area = mnsa_pkg::AREA_W'(site_area[best]);
            r.grew = 1'b1;
          end
        end
        mnsa_pkg::OP_CLEAR: begin
          foreach (site_grew[i]) site_grew[i] = 0;
        end
        mnsa_pkg::OP_READ: begin
          r.idx = idx;
          r.area = mnsa_pkg::AREA_W'(site_area[idx]);
          r.grew = site_grew[idx];
        end
        mnsa_pkg::OP_FIND: begin
          // Ungrown sites rank first, then larger area; a full tie keeps the lower slot.
          for (int i = 1; i < n; i++) begin
            if (site_grew[i] == site_grew[best]) better = site_area[i] > site_area[best];
            else better = !site_grew[i];
            if (better) best = i;
          end
          r.idx = mnsa_pkg::IDX_W'(best);
          r.area = mnsa_pkg::AREA_W'(site_area[best]);
          r.grew = site_grew[best];
        end
        default: begin
        end
      endcase
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [mnsa_pkg::M_TDATA_W-1:0] data);
      site_result_t got, want;
      got = data;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, data);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (got.idx !== want.idx) begin
        $display("%0t: nearest_index expected %0d actual %0d", $time, want.idx, got.idx);
        errors++;
      end
      if (got.tie !== want.tie) begin
        $display("%0t: tie expected %0d actual %0d", $time, want.tie, got.tie);
        errors++;
      end
      if (got.min_d !== want.min_d) begin
        $display("%0t: min_distance expected %0d actual %0d", $time, want.min_d, got.min_d);
        errors++;
      end
      if (got.area !== want.area) begin
        $display("%0t: area_count expected %0d actual %0d", $time, want.area, got.area);
        errors++;
      end
      if (got.grew !== want.grew) begin
        $display("%0t: grew_mark expected %0d actual %0d", $time, want.grew, got.grew);
        errors++;
      end
    endfunction
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [mnsa_pkg::CFG_W-1:0]     cfg_data_i = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [mnsa_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [mnsa_pkg::OP_W-1:0]      s_axis_tuser = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [mnsa_pkg::M_TDATA_W-1:0] m_axis_tdata;

  site_area_tracker tracker = new();
  int unsigned      cycle_count = 0;
  int unsigned      tx_idle_pct = 0;
  int unsigned      rx_stall_pct = 0;
  bit               calm = 0;
  bit               hold_request = 0;
  int unsigned      count_plan[7] = '{2, 64, 127, 3, 1, 40, 0};
  int unsigned      stall_menu[3] = '{0, 15, 40};

  manhattan_nearest_site_area uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) tracker.check_result(m_axis_tdata);
  end

  // Receiver: random stall bursts, plus one long hold-off so that the block backs up.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        m_axis_tready = 1'b0;
        for (int c = 0; c < 400; c++) @(negedge clk_i);
        hold_request = 0;
      end else if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else if (!calm && rst_ni && $urandom_range(0, 99) < rx_stall_pct) begin
        m_axis_tready = 1'b0;
        stall_left = $urandom_range(1, 13) - 1;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  task automatic send_query(logic [2:0] op, logic [mnsa_pkg::IDX_W-1:0] idx,
                            logic [mnsa_pkg::XY_W-1:0] cx, logic [mnsa_pkg::XY_W-1:0] cy);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = op;
    s_axis_tdata = {4'b0, cy, cx, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_query(op, idx, cx, cy);
  endtask

  // Only written with the input side quiet and every result back.
  task automatic write_site_count(int unsigned value);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (tracker.expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i = mnsa_pkg::CFG_W'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.site_count = value & 7'h7F;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Clustered values make ties and repeated credits common; the rest cover all bits.
  function automatic logic [mnsa_pkg::XY_W-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return mnsa_pkg::XY_W'($urandom_range(0, 32)) - mnsa_pkg::XY_W'(16);
      8:          return $urandom_range(0, 1) ? COORD_MIN : COORD_MAX;
      9:          return $urandom_range(0, 1) ? '0 : '1;
      default:    return mnsa_pkg::XY_W'($urandom);
    endcase
  endfunction

  task automatic random_query();
    int unsigned     w;
    logic [2:0]      op;
    w = $urandom_range(0, 99);
    if (w < 45) op = mnsa_pkg::OP_CLASSIFY;
    else if (w < 60) op = mnsa_pkg::OP_LOAD;
    else if (w < 72) op = mnsa_pkg::OP_READ;
    else if (w < 84) op = mnsa_pkg::OP_FIND;
    else if (w < 92) op = mnsa_pkg::OP_CLEAR;
    else op = 3'($urandom_range(mnsa_pkg::OP_FIND + 1, OP_LAST_CODE));
    send_query(op, mnsa_pkg::IDX_W'($urandom), pick_coord(), pick_coord());
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part with the reset site count of one.
    send_query(mnsa_pkg::OP_LOAD, 6'd0, COORD_MIN, COORD_MIN);
    send_query(mnsa_pkg::OP_CLASSIFY, 6'd0, COORD_MAX, COORD_MAX);
    send_query(mnsa_pkg::OP_CLASSIFY, 6'd0, COORD_MIN, COORD_MIN);
    send_query(mnsa_pkg::OP_READ, 6'd0, '0, '0);
    send_query(mnsa_pkg::OP_FIND, 6'd0, '0, '0);
    send_query(mnsa_pkg::OP_CLEAR, 6'd0, '0, '0);
    send_query(mnsa_pkg::OP_READ, 6'd0, '0, '0);
    send_query(mnsa_pkg::OP_READ, 6'd63, '0, '0);
    for (int c = mnsa_pkg::OP_FIND + 1; c <= OP_LAST_CODE; c++)
      send_query(3'(c), 6'h3F, 11'h7FF, COORD_MAX);
    send_query(mnsa_pkg::OP_LOAD, 6'd63, COORD_MAX, COORD_MAX);
    send_query(mnsa_pkg::OP_READ, 6'd63, '0, '0);
    send_query(mnsa_pkg::OP_LOAD, 6'd0, '0, '0);
    send_query(mnsa_pkg::OP_READ, 6'd0, '0, '0);
    send_query(mnsa_pkg::OP_CLASSIFY, 6'd0, 11'd5, -11'sd3);
    send_query(mnsa_pkg::OP_FIND, 6'd0, '0, '0);
    send_query(mnsa_pkg::OP_CLASSIFY, 6'd0, COORD_MAX, COORD_MIN);

    // A count of zero behaves as one; only slots 0 and 63 are loaded so far.
    write_site_count(0);
    tx_idle_pct = 20;
    rx_stall_pct = 20;
    repeat (20) random_query();

    // Load every slot before any larger count lets a classify reach it.
    for (int s = 0; s < mnsa_pkg::MAX_SITES; s++)
      send_query(mnsa_pkg::OP_LOAD, mnsa_pkg::IDX_W'(s), pick_coord(), pick_coord());

    foreach (count_plan[p]) begin
      write_site_count(count_plan[p]);
      tx_idle_pct = stall_menu[$urandom_range(0, 2)];
      rx_stall_pct = stall_menu[$urandom_range(0, 2)];
      if (p == 0) hold_request = 1;
      repeat (85) random_query();
    end

    write_site_count($urandom_range(1, 64));
    calm = 1;
    repeat (60) random_query();

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (tracker.expected_results.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
